// ===== src/ckc_pkg.sv =====
// Package for the chroma key compositor: field widths, operation codes and
// the command and status records between the controller and the datapath.
// No dependencies.
package ckc_pkg;

    localparam int PIX_W      = 8;
    localparam int OP_W       = 2;
    localparam int SUM_W      = 17;
    localparam int DSQ_W      = 18;
    localparam int SQ_W       = 16;
    localparam int THR_W      = 9;
    localparam int ROOT_W     = 9;
    localparam int ROOT_STEPS = 9;
    localparam int REM_W      = 11;
    localparam int CNT_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam int NUM_CH     = 3;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [PIX_W-1:0] KEY_MAX = {PIX_W{1'b1}};

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_BORDER = 2'd1;
    localparam logic [OP_W-1:0] OP_DEV    = 2'd2;
    localparam logic [OP_W-1:0] OP_KEY    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 1'd1;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [PIX_W-1:0] fg_red;
        logic [PIX_W-1:0] fg_green;
        logic [PIX_W-1:0] fg_blue;
        logic [PIX_W-1:0] bg_red;
        logic [PIX_W-1:0] bg_green;
        logic [PIX_W-1:0] bg_blue;
    } t_item;

    typedef struct packed {
        logic load;
        logic clear;
        logic acc;
        logic key_upd;
        logic square;
        logic emit;
        logic dev_upd;
        logic root_step;
        logic round;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            dev_gt;
        logic            out_busy;
    } t_sts;

endpackage

// ===== src/ckc_in_if.sv =====
// Input channel of the chroma key compositor: handshake plus item fields.
// Depends on ckc_pkg.
interface ckc_in_if;
    import ckc_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [PIX_W-1:0] fg_red;
    logic [PIX_W-1:0] fg_green;
    logic [PIX_W-1:0] fg_blue;
    logic [PIX_W-1:0] bg_red;
    logic [PIX_W-1:0] bg_green;
    logic [PIX_W-1:0] bg_blue;

    modport source (
        output valid, op, fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue,
        input  ready
    );
    modport sink (
        input  valid, op, fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue,
        output ready
    );
endinterface

// ===== src/ckc_out_if.sv =====
// Output channel of the chroma key compositor: handshake plus result fields.
// Depends on ckc_pkg.
interface ckc_out_if;
    import ckc_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic             keep_foreground;

    modport source (
        output valid, out_red, out_green, out_blue, keep_foreground,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, keep_foreground,
        output ready
    );
endinterface

// ===== src/ckc_datapath.sv =====
// Datapath of the chroma key compositor: calibration sums, key division by a
// constant reciprocal, distance squares, threshold compare, serial square root.
// Depends on ckc_pkg.
module ckc_datapath #(
    parameter int SIDE = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ckc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ckc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  ckc_pkg::t_item                  i_item,
    input  ckc_pkg::t_cmd                   i_cmd,
    output ckc_pkg::t_sts                   o_sts,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [ckc_pkg::PIX_W-1:0]       o_out_red,
    output logic [ckc_pkg::PIX_W-1:0]       o_out_green,
    output logic [ckc_pkg::PIX_W-1:0]       o_out_blue,
    output logic                            o_keep_foreground
);
    import ckc_pkg::*;

    // The key divides each sum by 2*SIDE. The reciprocal ceil(2^S / D) with
    // S = SUM_W + clog2(D) gives the exact truncated quotient for every sum.
    localparam int     DIVISOR   = 2 * SIDE;
    localparam int     DIV_SHIFT = SUM_W + $clog2(DIVISOR);
    localparam int     RCP_W     = SUM_W + 1;
    localparam int     PROD_W    = SUM_W + RCP_W;
    localparam longint RCP       = ((longint'(1) << DIV_SHIFT) + longint'(DIVISOR) - 1)
                                   / longint'(DIVISOR);
    localparam logic [RCP_W-1:0] RCP_K = RCP_W'(RCP);

    // Configuration.
    logic              r_mode;
    logic [THR_W-1:0]  r_thresh;

    // Calibration state.
    logic [SUM_W-1:0]  r_sum [NUM_CH];
    logic [PIX_W-1:0]  r_key [NUM_CH];
    logic [DSQ_W-1:0]  r_max;
    logic [DSQ_W-1:0]  r_thr1;

    // Latched item.
    t_item             r_item;

    // Next sums and next key colors, one lane per channel.
    logic [SUM_W-1:0]  n_sum [NUM_CH];
    logic [PIX_W-1:0]  n_key [NUM_CH];

    // Distance stage.
    logic [SQ_W-1:0]   r_sq [NUM_CH];
    logic [DSQ_W-1:0]  r_thr0;
    logic [PIX_W-1:0]  fg [NUM_CH];
    logic [PIX_W-1:0]  diff [NUM_CH];
    logic [DSQ_W-1:0]  d_sq;
    logic [DSQ_W-1:0]  thr;
    logic              keep;

    // Serial square root.
    logic [DSQ_W-1:0]  r_rad;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W-1:0]  r_rrem;
    logic [REM_W+1:0]  root_t;
    logic [REM_W+1:0]  root_trial;
    logic [ROOT_W:0]   root_up;

    // Result register.
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_out_red;
    logic [PIX_W-1:0]  r_out_green;
    logic [PIX_W-1:0]  r_out_blue;
    logic              r_out_keep;

    assign fg[0] = r_item.fg_red;
    assign fg[1] = r_item.fg_green;
    assign fg[2] = r_item.fg_blue;

    always_comb begin
        logic [SUM_W:0]    s;
        logic [PROD_W-1:0] prod;
        logic [SUM_W-1:0]  quo;
        for (int c = 0; c < NUM_CH; c++) begin
            s = {1'b0, r_sum[c]} + (SUM_W + 1)'(fg[c]);
            n_sum[c] = (s > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX : s[SUM_W-1:0];
            prod = PROD_W'(r_sum[c]) * PROD_W'(RCP_K);
            quo  = SUM_W'(prod >> DIV_SHIFT);
            n_key[c] = (quo > SUM_W'(KEY_MAX)) ? KEY_MAX : quo[PIX_W-1:0];
            diff[c] = (fg[c] > r_key[c]) ? fg[c] - r_key[c] : r_key[c] - fg[c];
        end
    end

    assign d_sq = DSQ_W'(r_sq[0]) + DSQ_W'(r_sq[1]) + DSQ_W'(r_sq[2]);
    assign thr  = r_mode ? r_thr1 : r_thr0;
    assign keep = (d_sq >= thr);

    assign root_t     = {r_rrem, r_rad[DSQ_W-1 -: 2]};
    assign root_trial = (REM_W + 2)'({r_root, 2'b01});
    assign root_up    = {1'b0, r_root} + (ROOT_W + 1)'(r_rrem != '0);

    assign o_sts.op       = r_item.op;
    assign o_sts.dev_gt   = (d_sq > r_max);
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_thresh    <= '0;
            r_max       <= '0;
            r_thr1      <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < NUM_CH; c++) begin
                r_sum[c] <= '0;
                r_key[c] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MODE:   r_mode   <= i_cfg_data[0];
                    CFG_THRESH: r_thresh <= i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clear) begin
                r_max  <= '0;
                r_thr1 <= '0;
                for (int c = 0; c < NUM_CH; c++) begin
                    r_sum[c] <= '0;
                    r_key[c] <= '0;
                end
            end
            if (i_cmd.acc) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    r_sum[c] <= n_sum[c];
                end
            end
            if (i_cmd.key_upd) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    r_key[c] <= n_key[c];
                end
            end
            if (i_cmd.dev_upd) begin
                r_max <= d_sq;
            end
            if (i_cmd.round) begin
                r_thr1 <= DSQ_W'(root_up) * DSQ_W'(root_up);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.square) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_sq[c] <= SQ_W'(diff[c]) * SQ_W'(diff[c]);
            end
            r_thr0 <= DSQ_W'(r_thresh) * DSQ_W'(r_thresh);
        end
        if (i_cmd.dev_upd) begin
            r_rad  <= d_sq;
            r_root <= '0;
            r_rrem <= '0;
        end else if (i_cmd.root_step) begin
            r_rad <= {r_rad[DSQ_W-3:0], 2'b00};
            if (root_t >= root_trial) begin
                r_rrem <= REM_W'(root_t - root_trial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rrem <= REM_W'(root_t);
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.emit) begin
            r_out_keep  <= keep;
            r_out_red   <= keep ? r_item.fg_red   : r_item.bg_red;
            r_out_green <= keep ? r_item.fg_green : r_item.bg_green;
            r_out_blue  <= keep ? r_item.fg_blue  : r_item.bg_blue;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_red         = r_out_red;
    assign o_out_green       = r_out_green;
    assign o_out_blue        = r_out_blue;
    assign o_keep_foreground = r_out_keep;

endmodule

// ===== src/ckc_ctrl.sv =====
// Controller of the chroma key compositor: sequences each item through the
// datapath by command signals. Depends on ckc_pkg.
module ckc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ckc_pkg::t_sts i_sts,
    output ckc_pkg::t_cmd o_cmd
);
    import ckc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_ROOT  = 3'd4;
    localparam logic [2:0] ST_ROUND = 3'd5;

    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_STEPS - 1);

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (i_sts.op)
                    OP_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_IDLE;
                    end
                    OP_BORDER: begin
                        o_cmd.acc = 1'b1;
                        n_state   = ST_DIV;
                    end
                    default: begin
                        o_cmd.square = 1'b1;
                        n_state      = ST_EVAL;
                    end
                endcase
            end
            ST_DIV: begin
                o_cmd.key_upd = 1'b1;
                n_state       = ST_IDLE;
            end
            ST_EVAL: begin
                if (i_sts.op == OP_KEY) begin
                    if (!i_sts.out_busy) begin
                        o_cmd.emit = 1'b1;
                        n_state    = ST_IDLE;
                    end
                end else if (i_sts.dev_gt) begin
                    o_cmd.dev_upd = 1'b1;
                    n_cnt         = '0;
                    n_state       = ST_ROOT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == ROOT_LAST) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== src/chroma_key_compositor.sv =====
// Chroma key compositor top level: joins the controller and the datapath to
// the input and output channels. Depends on ckc_pkg, ckc_in_if, ckc_out_if.
//
// The block learns a key color from border pixels and then keys foreground
// pixels against it. A clear item resets the calibration. A border sum item
// adds its foreground pixel to three saturating channel sums; the key color is
// each sum divided by 2*SIDE, truncated and clamped to 255. A deviation item
// keeps the largest squared distance of a border pixel from the key color and,
// when it grows, derives the smallest perfect square at or above it as the
// squared threshold for mode 1. A key pixel item produces one result: the
// foreground pixel when its squared distance from the key color reaches the
// squared threshold (distance_threshold squared in mode 0), otherwise the
// background pixel. Only key pixel items produce results. One item is worked
// on at a time: a clear is accepted and then executed, a key pixel or a
// deviation sample is accepted, squared and compared, a deviation sample
// that raises the maximum then runs the bit-serial square root and its
// rounding, and a border sum sample is accepted, accumulated and turned into
// a key update, where the key color comes from multiplying each sum by a
// constant reciprocal of 2*SIDE. A key pixel also waits while the previous
// result is still held in the output register. Configuration must be written
// only while no item is in flight.
module chroma_key_compositor #(
    parameter int SIDE = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ckc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ckc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    ckc_in_if.sink                          i_pix,
    ckc_out_if.source                       o_pix
);
    import ckc_pkg::*;

    t_item item;
    t_cmd  cmd;
    t_sts  sts;

    assign item.op       = i_pix.op;
    assign item.fg_red   = i_pix.fg_red;
    assign item.fg_green = i_pix.fg_green;
    assign item.fg_blue  = i_pix.fg_blue;
    assign item.bg_red   = i_pix.bg_red;
    assign item.bg_green = i_pix.bg_green;
    assign item.bg_blue  = i_pix.bg_blue;

    // The controller sequences every item; it is ready only between items.
    ckc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the configuration, the calibration and the result
    // register that drives the output channel.
    ckc_datapath #(
        .SIDE (SIDE)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_item            (item),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_out_ready       (o_pix.ready),
        .o_out_valid       (o_pix.valid),
        .o_out_red         (o_pix.out_red),
        .o_out_green       (o_pix.out_green),
        .o_out_blue        (o_pix.out_blue),
        .o_keep_foreground (o_pix.keep_foreground)
    );

endmodule

// ===== test/chroma_key_compositor_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for chroma_key_compositor: random handshakes on both channels,
// with a built-in model of the calibration state that predicts every keyed pixel.
// Depends on ckc_pkg, ckc_in_if, ckc_out_if and the chroma_key_compositor RTL.
module chroma_key_compositor_tb;
    import ckc_pkg::*;

    localparam int SIDE = 256;

    typedef struct {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             keep;
    } t_composite;

    // Tracks the calibration and configuration that the block should hold, and the
    // composited pixels that are still owed by the block, oldest first.
    class key_pixel_checker;
        int unsigned key_div;
        int unsigned red_sum, green_sum, blue_sum;
        int unsigned max_dev_sq, auto_thr_sq, auto_root;
        bit          mode_sel;
        int unsigned dist_thr;
        int unsigned mismatches;
        t_composite  owed_pixels[$];

        function new(int unsigned side);
            key_div    = 2 * side;
            mismatches = 0;
            mode_sel   = 1'b0;
            dist_thr   = 0;
            clear_calibration();
        endfunction

        function void clear_calibration();
            red_sum     = 0;
            green_sum   = 0;
            blue_sum    = 0;
            max_dev_sq  = 0;
            auto_thr_sq = 0;
            auto_root   = 0;
        endfunction

        function int unsigned sum_in(int unsigned s, int unsigned v);
            return (s + v > 131071) ? 131071 : s + v;
        endfunction

        function int unsigned key_color(int ch);
            int unsigned s;
            s = (ch == 0) ? red_sum : (ch == 1) ? green_sum : blue_sum;
            return (s / key_div > 255) ? 255 : s / key_div;
        endfunction

        function int unsigned dist_sq(t_item it);
            int dr, dg, db;
            dr = int'(it.fg_red)   - int'(key_color(0));
            dg = int'(it.fg_green) - int'(key_color(1));
            db = int'(it.fg_blue)  - int'(key_color(2));
            return dr * dr + dg * dg + db * db;
        endfunction

        // Distance that separates kept from replaced pixels under the current mode.
        function int unsigned threshold_root();
            return mode_sel ? auto_root : dist_thr;
        endfunction

        function int pending();
            return owed_pixels.size();
        endfunction

        function void note_item(t_item it);
            int unsigned d, thr_sq, r;
            t_composite  px;
            case (it.op)
                OP_CLEAR: clear_calibration();
                OP_BORDER: begin
                    red_sum   = sum_in(red_sum, it.fg_red);
                    green_sum = sum_in(green_sum, it.fg_green);
                    blue_sum  = sum_in(blue_sum, it.fg_blue);
                end
                OP_DEV: begin
                    d = dist_sq(it);
                    if (d > max_dev_sq) begin
                        // Smallest perfect square at or above the new maximum.
                        max_dev_sq = d;
                        r = 0;
                        while ((r + 1) * (r + 1) <= d) r++;
                        if (r * r < d) r++;
                        auto_root   = r;
                        auto_thr_sq = r * r;
                    end
                end
                default: begin
                    d      = dist_sq(it);
                    thr_sq = mode_sel ? auto_thr_sq : dist_thr * dist_thr;
                    px.keep = (d >= thr_sq);
                    px.red   = px.keep ? it.fg_red   : it.bg_red;
                    px.green = px.keep ? it.fg_green : it.bg_green;
                    px.blue  = px.keep ? it.fg_blue  : it.bg_blue;
                    owed_pixels.push_back(px);
                end
            endcase
        endfunction

        function void check_result(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                   logic [PIX_W-1:0] b, logic keep);
            t_composite want;
            if (owed_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected pixel %02h %02h %02h keep %b",
                             $realtime, r, g, b, keep);
                return;
            end
            want = owed_pixels.pop_front();
            if (r !== want.red || g !== want.green || b !== want.blue ||
                keep !== want.keep) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: expected %02h %02h %02h keep %b, got %02h %02h %02h keep %b",
                             $realtime, want.red, want.green, want.blue, want.keep,
                             r, g, b, keep);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ckc_in_if  pix_in ();
    ckc_out_if pix_out ();

    chroma_key_compositor #(.SIDE(SIDE)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pix_in),
        .o_pix       (pix_out)
    );

    key_pixel_checker chk = new(SIDE);

    // When set, the matching side runs without gaps or stalls for a whole phase.
    bit in_calm;
    bit out_calm;
    int ready_left  = 0;
    bit ready_level = 1'b0;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #30ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: check every accepted pixel, then pick the next ready level.
    // Stalls are mostly short, with the occasional long one.
    always @(posedge i_clk) begin
        if (i_rst_n && pix_out.valid && pix_out.ready)
            chk.check_result(pix_out.out_red, pix_out.out_green, pix_out.out_blue,
                             pix_out.keep_foreground);
        if (ready_left > 0) begin
            ready_left--;
        end else if (out_calm) begin
            ready_level = 1'b1;
            ready_left  = $urandom_range(1, 8);
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    ready_level = 1'b1;
                    ready_left  = $urandom_range(1, 12);
                end
                6, 7, 8: begin
                    ready_level = 1'b0;
                    ready_left  = $urandom_range(1, 3);
                end
                default: begin
                    ready_level = 1'b0;
                    ready_left  = $urandom_range(15, 50);
                end
            endcase
        end
        pix_out.ready <= ready_level;
    end

    function automatic logic [PIX_W-1:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (in_calm) return 0;
        r = $urandom_range(0, 19);
        if (r < 11) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_item random_item(logic [OP_W-1:0] op);
        t_item it;
        it.op       = op;
        it.fg_red   = rand_byte();
        it.fg_green = rand_byte();
        it.fg_blue  = rand_byte();
        it.bg_red   = rand_byte();
        it.bg_green = rand_byte();
        it.bg_blue  = rand_byte();
        return it;
    endfunction

    // Style 0 is a random pixel, style 1 a pixel scattered around the key color,
    // and style 2 a pixel whose distance along one channel sits at the threshold,
    // one below it or one above it.
    function automatic t_item pixel_item(logic [OP_W-1:0] op, int style);
        t_item it;
        int    px[3];
        int    ch, off, spread, root;
        it = random_item(op);
        if (style == 0) return it;
        root = int'(chk.threshold_root());
        for (int c = 0; c < 3; c++) px[c] = int'(chk.key_color(c));
        if (style == 1) begin
            spread = root / 2 + 3;
            for (int c = 0; c < 3; c++) begin
                px[c] = px[c] + int'($urandom_range(0, 2 * spread)) - spread;
                if (px[c] < 0) px[c] = 0;
                if (px[c] > 255) px[c] = 255;
            end
        end else begin
            ch  = $urandom_range(0, 2);
            off = root + int'($urandom_range(0, 2)) - 1;
            if (off < 0) off = 1;
            if ($urandom_range(0, 1) == 0 && px[ch] - off >= 0) px[ch] = px[ch] - off;
            else if (px[ch] + off <= 255) px[ch] = px[ch] + off;
            else if (px[ch] - off >= 0) px[ch] = px[ch] - off;
            else px[ch] = $urandom_range(0, 255);
        end
        it.fg_red   = 8'(px[0]);
        it.fg_green = 8'(px[1]);
        it.fg_blue  = 8'(px[2]);
        return it;
    endfunction

    // Called at a clock edge. Valid stays high after acceptance so that a follow-up
    // item without a gap goes out back to back.
    task automatic push_item(input t_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.op       <= it.op;
        pix_in.fg_red   <= it.fg_red;
        pix_in.fg_green <= it.fg_green;
        pix_in.fg_blue  <= it.fg_blue;
        pix_in.bg_red   <= it.bg_red;
        pix_in.bg_green <= it.bg_green;
        pix_in.bg_blue  <= it.bg_blue;
        do @(posedge i_clk); while (!pix_in.ready);
        chk.note_item(it);
    endtask

    // Border and deviation items give no result, so after the last pixel comes
    // back the block may still be busy; the extra cycles cover its longest item.
    task automatic settle();
        pix_in.valid <= 1'b0;
        while (chk.pending() != 0) @(posedge i_clk);
        repeat (32) @(posedge i_clk);
    endtask

    // The upper data bits of the mode write are junk that the block must drop.
    task automatic set_config(input bit mode_bit, input int thr);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MODE;
        i_cfg_data  <= {8'($urandom_range(0, 255)), mode_bit};
        @(posedge i_clk);
        i_cfg_index <= CFG_THRESH;
        i_cfg_data  <= 9'(thr);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        chk.mode_sel = mode_bit;
        chk.dist_thr = thr;
    endtask

    // One calibration and keying pass: configure, learn a key color from border
    // pixels around a per-phase base color, record deviations, then key pixels
    // with a sprinkling of random items of any kind.
    task automatic run_phase(input bit no_dev);
        int    n_border, n_dev, n_key, thr, v;
        int    base[3];
        bit    mode_bit;
        t_item it;
        settle();
        in_calm  = ($urandom_range(0, 4) == 0);
        out_calm = ($urandom_range(0, 4) == 0);
        mode_bit = no_dev ? 1'b1 : 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0:       thr = 0;
            1:       thr = 443;
            2:       thr = 511;
            3:       thr = $urandom_range(1, 24);
            default: thr = $urandom_range(0, 443);
        endcase
        set_config(mode_bit, thr);
        if (no_dev || $urandom_range(0, 3) != 0)
            push_item(random_item(OP_CLEAR));
        case ($urandom_range(0, 4))
            0:       n_border = 0;
            1:       n_border = $urandom_range(1, 12);
            default: n_border = $urandom_range(16, 48);
        endcase
        for (int c = 0; c < 3; c++) base[c] = $urandom_range(0, 255);
        repeat (n_border) begin
            it = random_item(OP_BORDER);
            if ($urandom_range(0, 3) != 0) begin
                for (int c = 0; c < 3; c++) begin
                    v = base[c] + int'($urandom_range(0, 60)) - 30;
                    if (v < 0) v = 0;
                    if (v > 255) v = 255;
                    if (c == 0) it.fg_red = 8'(v);
                    else if (c == 1) it.fg_green = 8'(v);
                    else it.fg_blue = 8'(v);
                end
            end
            push_item(it);
        end
        n_dev = no_dev ? 0 : $urandom_range(0, 6);
        repeat (n_dev) push_item(pixel_item(OP_DEV, $urandom_range(0, 1)));
        n_key = $urandom_range(16, 36);
        repeat (n_key) begin
            if ($urandom_range(0, 11) == 0)
                push_item(random_item(OP_W'($urandom_range(0, 3))));
            else
                push_item(pixel_item(OP_KEY, $urandom_range(0, 2)));
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= CFG_MODE;
        i_cfg_data       <= '0;
        pix_in.valid     <= 1'b0;
        pix_in.op        <= OP_CLEAR;
        pix_in.fg_red    <= '0;
        pix_in.fg_green  <= '0;
        pix_in.fg_blue   <= '0;
        pix_in.bg_red    <= '0;
        pix_in.bg_green  <= '0;
        pix_in.bg_blue   <= '0;
        in_calm          = 1'b0;
        out_calm         = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero threshold with an all-zero key: every pixel keeps its foreground.
        set_config(1'b0, 0);
        push_item('{OP_KEY, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff});
        push_item('{OP_KEY, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00});

        // A threshold of 443 exceeds the farthest possible pixel.
        settle();
        set_config(1'b0, 443);
        push_item('{OP_KEY, 8'hff, 8'hff, 8'hff, 8'h12, 8'h34, 8'h56});
        push_item('{OP_KEY, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff});

        // Mode 1 before any deviation sample: threshold is zero, all kept.
        settle();
        set_config(1'b1, 443);
        push_item('{OP_KEY, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff});
        push_item('{OP_DEV, 8'hff, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00});
        push_item('{OP_DEV, 8'h10, 8'h10, 8'h10, 8'hff, 8'hff, 8'hff});
        push_item('{OP_KEY, 8'hff, 8'h00, 8'h80, 8'ha5, 8'h5a, 8'h3c});
        push_item('{OP_KEY, 8'hff, 8'h00, 8'hff, 8'h01, 8'h02, 8'h03});
        push_item('{OP_KEY, 8'h00, 8'h00, 8'h00, 8'hc3, 8'h3c, 8'h99});
        push_item('{OP_BORDER, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
        push_item('{OP_BORDER, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        push_item('{OP_BORDER, 8'hff, 8'h00, 8'h80, 8'h55, 8'haa, 8'h0f});
        push_item('{OP_CLEAR, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
        push_item('{OP_KEY, 8'h80, 8'h80, 8'h80, 8'h01, 8'h01, 8'h01});

        // A deviation that is already a perfect square: distance equal to the
        // threshold keeps the foreground, one step short of it does not.
        push_item('{OP_DEV, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00});
        push_item('{OP_KEY, 8'h03, 8'h04, 8'h00, 8'hee, 8'hdd, 8'hcc});
        push_item('{OP_KEY, 8'h04, 8'h00, 8'h00, 8'hee, 8'hdd, 8'hcc});

        // The first phase runs mode 1 after a clear, with no deviation samples ahead of its key pixels.
        for (int p = 0; p < 8; p++)
            run_phase(p == 0);

        settle();
        repeat (40) @(posedge i_clk);
        if (chk.mismatches == 0 && chk.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
